/* design/raf_pkg.sv */
// Package with the shared widths, register indexes and pipeline word types.
`default_nettype none
package raf_pkg;

   localparam int unsigned COORD_W = 12;
   localparam int unsigned ALPHA_W = 8;
   localparam int unsigned SCALE_W = 17;
   localparam int unsigned SUM_W   = 25;
   localparam int unsigned ROOT_W  = 13;
   localparam int unsigned PROD_W  = ROOT_W + SCALE_W;
   localparam int unsigned CSR_IDX_W = 2;

   // Front end takes three stages, the multiply and the output register two more.
   localparam int unsigned LATENCY = 5 + ROOT_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_COL    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ROW    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ALPHA     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALLOFF_SCALE = 2'd3;

   localparam logic [ALPHA_W-1:0] MAX_ALPHA_RESET     = 8'd255;
   localparam logic [SCALE_W-1:0] FALLOFF_SCALE_RESET = 17'd256;

   typedef struct packed {
      logic               valid;
      logic               zero;
      logic [ALPHA_W-1:0] scaled;
      logic               last;
   } side_type;

   typedef struct packed {
      side_type          side;
      logic [SUM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } cell_type;

endpackage
`default_nettype wire

/* design/radial_alpha_falloff_top.sv */
// Top level of the radial alpha falloff pipeline.
// The block takes one pixel word in every clock cycle: busy never rises, and
// each pixel's result is on the rsp_ ports, marked by rsp_valid, once it has
// passed three front stages, thirteen square root cells with one root bit each,
// the falloff multiply and the result register. Results are shown for one
// cycle only and cannot be stalled, so the receiver must take every word as it
// comes. Register writes are taken at any time on the csr_ port and should be
// made while no pixel is in flight.
`default_nettype none
module radial_alpha_falloff_top (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [raf_pkg::COORD_W-1:0]   req_pixel_row,
   input  wire logic [raf_pkg::COORD_W-1:0]   req_pixel_col,
   input  wire logic [raf_pkg::ALPHA_W-1:0]   req_pixel_alpha,
   input  wire logic                          req_last_in_region,
   output logic                               rsp_valid,
   output logic [raf_pkg::ALPHA_W-1:0]        rsp_new_alpha,
   output logic                               rsp_last_out,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [raf_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [raf_pkg::SCALE_W-1:0]   csr_wdata
);

   logic [raf_pkg::COORD_W-1:0] center_col_ff, center_row_ff;
   logic [raf_pkg::ALPHA_W-1:0] max_alpha_ff;
   logic [raf_pkg::SCALE_W-1:0] falloff_scale_ff;
   logic                        accept;
   raf_pkg::cell_type           chain [raf_pkg::ROOT_W+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_col_ff    <= '0;
         center_row_ff    <= '0;
         max_alpha_ff     <= raf_pkg::MAX_ALPHA_RESET;
         falloff_scale_ff <= raf_pkg::FALLOFF_SCALE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            raf_pkg::CSR_CENTER_COL: begin
               center_col_ff <= csr_wdata[raf_pkg::COORD_W-1:0];
            end
            raf_pkg::CSR_CENTER_ROW: begin
               center_row_ff <= csr_wdata[raf_pkg::COORD_W-1:0];
            end
            raf_pkg::CSR_MAX_ALPHA: begin
               max_alpha_ff <= csr_wdata[raf_pkg::ALPHA_W-1:0];
            end
            raf_pkg::CSR_FALLOFF_SCALE: begin
               falloff_scale_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   raf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .pixel_row      (req_pixel_row),
      .pixel_col      (req_pixel_col),
      .pixel_alpha    (req_pixel_alpha),
      .last_in_region (req_last_in_region),
      .center_row     (center_row_ff),
      .center_col     (center_col_ff),
      .max_alpha      (max_alpha_ff),
      .cell_out       (chain[0])
   );

   // The first cell settles the most significant root bit.
   for (genvar g = 0; g < raf_pkg::ROOT_W; g++) begin : g_cell
      raf_sqrt_cell #(
         .BIT_POS (raf_pkg::ROOT_W - 1 - g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[g]),
         .cell_out (chain[g+1])
      );
   end

   raf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cell_in       (chain[raf_pkg::ROOT_W]),
      .falloff_scale (falloff_scale_ff),
      .rsp_valid     (rsp_valid),
      .rsp_new_alpha (rsp_new_alpha),
      .rsp_last_out  (rsp_last_out)
   );

endmodule
`default_nettype wire

/* design/raf_front.sv */
// Front end: distances to the center, alpha scaling, squares and their sum.
`default_nettype none
module raf_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [raf_pkg::COORD_W-1:0]   pixel_row,
   input  wire logic [raf_pkg::COORD_W-1:0]   pixel_col,
   input  wire logic [raf_pkg::ALPHA_W-1:0]   pixel_alpha,
   input  wire logic                          last_in_region,
   input  wire logic [raf_pkg::COORD_W-1:0]   center_row,
   input  wire logic [raf_pkg::COORD_W-1:0]   center_col,
   input  wire logic [raf_pkg::ALPHA_W-1:0]   max_alpha,
   output raf_pkg::cell_type                  cell_out
);

   logic [raf_pkg::COORD_W-1:0]   dy_ff, dy_in, dx_ff, dx_in;
   raf_pkg::side_type             side1_ff, side1_in, side2_ff, side3_ff;
   logic [2*raf_pkg::COORD_W-1:0] sqy_ff, sqx_ff;
   logic [raf_pkg::SUM_W-1:0]     sum_ff;
   logic [2*raf_pkg::ALPHA_W-1:0] alpha_prod;

   always_comb begin
      dy_in = (center_row >= pixel_row) ? center_row - pixel_row : pixel_row - center_row;
      dx_in = (center_col >= pixel_col) ? center_col - pixel_col : pixel_col - center_col;
      alpha_prod = pixel_alpha * max_alpha;
      side1_in.valid  = accept;
      side1_in.zero   = (pixel_alpha == '0);
      side1_in.scaled = alpha_prod[2*raf_pkg::ALPHA_W-1:raf_pkg::ALPHA_W];
      side1_in.last   = last_in_region;
   end

   always_ff @(posedge clock) begin
      dy_ff    <= dy_in;
      dx_ff    <= dx_in;
      sqy_ff   <= dy_ff * dy_ff;
      sqx_ff   <= dx_ff * dx_ff;
      sum_ff   <= raf_pkg::SUM_W'(sqy_ff) + raf_pkg::SUM_W'(sqx_ff);
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
         side3_ff <= '0;
      end else begin
         side1_ff <= side1_in;
         side2_ff <= side1_ff;
         side3_ff <= side2_ff;
      end
   end

   always_comb begin
      cell_out.side = side3_ff;
      cell_out.rem  = sum_ff;
      cell_out.root = '0;
   end

endmodule
`default_nettype wire

/* design/raf_sqrt_cell.sv */
// One cell of the square root chain: settles one bit of the root per stage.
`default_nettype none
module raf_sqrt_cell #(
   parameter int unsigned BIT_POS = 0
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire raf_pkg::cell_type cell_in,
   output raf_pkg::cell_type      cell_out
);

   localparam int unsigned TEST_W = raf_pkg::SUM_W + 2;

   raf_pkg::cell_type cell_ff, cell_in_next;
   logic [TEST_W-1:0] test;

   // The remainder holds the operand minus the square of the root so far;
   // setting this bit costs (root << (BIT_POS + 1)) + 4**BIT_POS.
   always_comb begin
      test = (TEST_W'(cell_in.root) << (BIT_POS + 1)) + (TEST_W'(1) << (2 * BIT_POS));
      cell_in_next = cell_in;
      if (TEST_W'(cell_in.rem) >= test) begin
         cell_in_next.rem  = cell_in.rem - test[raf_pkg::SUM_W-1:0];
         cell_in_next.root = cell_in.root | (raf_pkg::ROOT_W'(1) << BIT_POS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff <= '0;
      end else begin
         cell_ff <= cell_in_next;
      end
   end

   assign cell_out = cell_ff;

endmodule
`default_nettype wire

/* design/raf_back.sv */
// Back end: falloff multiply, subtraction with clamp and the result register.
`default_nettype none
module raf_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire raf_pkg::cell_type           cell_in,
   input  wire logic [raf_pkg::SCALE_W-1:0] falloff_scale,
   output logic                             rsp_valid,
   output logic [raf_pkg::ALPHA_W-1:0]      rsp_new_alpha,
   output logic                             rsp_last_out
);

   localparam int unsigned DROP_W = raf_pkg::PROD_W - 8;

   raf_pkg::side_type            side_ff;
   logic [raf_pkg::PROD_W-1:0]   prod_ff;
   logic [DROP_W-1:0]            drop;
   logic [raf_pkg::ALPHA_W-1:0]  alpha_in, alpha_ff;
   logic                         valid_ff, last_ff;

   always_comb begin
      drop = prod_ff[raf_pkg::PROD_W-1:8];
      alpha_in = '0;
      if (!side_ff.zero && DROP_W'(side_ff.scaled) > drop) begin
         alpha_in = side_ff.scaled - drop[raf_pkg::ALPHA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= raf_pkg::PROD_W'(cell_in.root) * raf_pkg::PROD_W'(falloff_scale);
      alpha_ff <= alpha_in;
      last_ff  <= side_ff.last;
      if (reset) begin
         side_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         side_ff  <= cell_in.side;
         valid_ff <= side_ff.valid;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_new_alpha = alpha_ff;
   assign rsp_last_out  = last_ff;

endmodule
`default_nettype wire

/* design/raf_checker.sv */
// Port level checker for the falloff block and its bind to the top level.
`default_nettype none
module raf_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        start,
   input wire logic                        busy,
   input wire logic [raf_pkg::ALPHA_W-1:0] req_pixel_alpha,
   input wire logic                        req_last_in_region,
   input wire logic                        rsp_valid,
   input wire logic [raf_pkg::ALPHA_W-1:0] rsp_new_alpha,
   input wire logic                        rsp_last_out
);

   logic accept;
   assign accept = start && !busy && !reset;

   // Every accepted word comes out after the fixed latency.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(raf_pkg::LATENCY) rsp_valid)
      else $error("accepted word did not produce a result in time");

   // No result appears without a word accepted that many cycles earlier.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, raf_pkg::LATENCY))
      else $error("result without a matching accepted word");

   // A transparent pixel stays transparent.
   a_zero_alpha: assert property (@(posedge clock) disable iff (reset)
      (accept && req_pixel_alpha == '0) |-> ##(raf_pkg::LATENCY) (rsp_new_alpha == '0))
      else $error("zero alpha did not pass through as zero");

   // The region end flag travels with its pixel.
   a_last: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(raf_pkg::LATENCY)
         (rsp_last_out == $past(req_last_in_region, raf_pkg::LATENCY)))
      else $error("last flag does not match its pixel");

   // Results never exceed the input alpha.
   a_bound: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##(raf_pkg::LATENCY)
         (rsp_new_alpha <= $past(req_pixel_alpha, raf_pkg::LATENCY)))
      else $error("result alpha above input alpha");

endmodule

bind radial_alpha_falloff_top raf_checker u_raf_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_pixel_alpha    (req_pixel_alpha),
   .req_last_in_region (req_last_in_region),
   .rsp_valid          (rsp_valid),
   .rsp_new_alpha      (rsp_new_alpha),
   .rsp_last_out       (rsp_last_out)
);
`default_nettype wire

/* test/tb_radial_alpha_falloff_top.sv */
// Self-checking testbench for the radial alpha falloff pipeline top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_radial_alpha_falloff_top;

   typedef struct packed {
      logic [raf_pkg::ALPHA_W-1:0] alpha;
      logic                        last;
   } falloff_word_type;

   // Holds the register copy and the queue of alpha words still to come out.
   class falloff_predictor_type;
      logic [raf_pkg::COORD_W-1:0] center_col;
      logic [raf_pkg::COORD_W-1:0] center_row;
      logic [raf_pkg::ALPHA_W-1:0] max_alpha;
      logic [raf_pkg::SCALE_W-1:0] falloff_scale;
      falloff_word_type            expected_words[$];
      int                          errors;

      function new();
         errors = 0;
         reset_regs();
      endfunction

      function void reset_regs();
         center_col    = '0;
         center_row    = '0;
         max_alpha     = raf_pkg::MAX_ALPHA_RESET;
         falloff_scale = raf_pkg::FALLOFF_SCALE_RESET;
      endfunction

      function void write_reg(logic [raf_pkg::CSR_IDX_W-1:0] index,
                              logic [raf_pkg::SCALE_W-1:0] data);
         case (index)
            raf_pkg::CSR_CENTER_COL:    center_col    = data[raf_pkg::COORD_W-1:0];
            raf_pkg::CSR_CENTER_ROW:    center_row    = data[raf_pkg::COORD_W-1:0];
            raf_pkg::CSR_MAX_ALPHA:     max_alpha     = data[raf_pkg::ALPHA_W-1:0];
            raf_pkg::CSR_FALLOFF_SCALE: falloff_scale = data;
            default: ;
         endcase
      endfunction

      // Exact floor of the square root, one result bit per pass.
      function longint unsigned floor_root(longint unsigned v);
         longint unsigned root;
         longint unsigned probe;
         root  = 0;
         probe = 64'd1 << 62;
         while (probe > v)
            probe >>= 2;
         while (probe != 0) begin
            if (v >= root + probe) begin
               v    -= root + probe;
               root  = (root >> 1) + probe;
            end else begin
               root >>= 1;
            end
            probe >>= 2;
         end
         return root;
      endfunction

      function logic [raf_pkg::ALPHA_W-1:0] falloff_alpha(
            logic [raf_pkg::COORD_W-1:0] row,
            logic [raf_pkg::COORD_W-1:0] col,
            logic [raf_pkg::ALPHA_W-1:0] alpha);
         longint unsigned dy, dx, radius, drop, scaled, level;
         if (alpha == 0)
            return '0;
         dy     = (row >= center_row) ? longint'(row) - center_row
                                      : longint'(center_row) - row;
         dx     = (col >= center_col) ? longint'(col) - center_col
                                      : longint'(center_col) - col;
         radius = floor_root(dy * dy + dx * dx);
         drop   = (radius * longint'(falloff_scale)) >> 8;
         scaled = (longint'(alpha) * longint'(max_alpha)) >> 8;
         level  = (scaled > drop) ? scaled - drop : 0;
         if (level > alpha)
            level = 0;
         return level[raf_pkg::ALPHA_W-1:0];
      endfunction

      function void note_pixel(logic [raf_pkg::COORD_W-1:0] row,
                               logic [raf_pkg::COORD_W-1:0] col,
                               logic [raf_pkg::ALPHA_W-1:0] alpha, logic last);
         falloff_word_type word;
         word.alpha = falloff_alpha(row, col, alpha);
         word.last  = last;
         expected_words.push_back(word);
      endfunction

      function void check_word(logic [raf_pkg::ALPHA_W-1:0] alpha, logic last);
         falloff_word_type want;
         if (expected_words.size() == 0) begin
            $display("%0t: result word with none expected: new_alpha %0d last_out %0d",
                     $time, alpha, last);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (alpha !== want.alpha) begin
            $display("%0t: new_alpha mismatch: expected %0d, actual %0d",
                     $time, want.alpha, alpha);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last_out mismatch: expected %0d, actual %0d",
                     $time, want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_words.size();
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          start = 1'b0;
   logic                          busy;
   logic [raf_pkg::COORD_W-1:0]   req_pixel_row = '0;
   logic [raf_pkg::COORD_W-1:0]   req_pixel_col = '0;
   logic [raf_pkg::ALPHA_W-1:0]   req_pixel_alpha = '0;
   logic                          req_last_in_region = 1'b0;
   logic                          rsp_valid;
   logic [raf_pkg::ALPHA_W-1:0]   rsp_new_alpha;
   logic                          rsp_last_out;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [raf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [raf_pkg::SCALE_W-1:0]   csr_wdata = '0;

   falloff_predictor_type book = new();

   radial_alpha_falloff_top uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_pixel_row      (req_pixel_row),
      .req_pixel_col      (req_pixel_col),
      .req_pixel_alpha    (req_pixel_alpha),
      .req_last_in_region (req_last_in_region),
      .rsp_valid          (rsp_valid),
      .rsp_new_alpha      (rsp_new_alpha),
      .rsp_last_out       (rsp_last_out),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // All handshakes are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      if (reset) begin
         book.reset_regs();
      end else begin
         if (start && !busy)
            book.note_pixel(req_pixel_row, req_pixel_col, req_pixel_alpha,
                            req_last_in_region);
         if (rsp_valid !== 1'b0)
            book.check_word(rsp_new_alpha, rsp_last_out);
         if (csr_valid && csr_ready)
            book.write_reg(csr_index, csr_wdata);
      end
   end

   task automatic send_pixel(input logic [raf_pkg::COORD_W-1:0] row,
                             input logic [raf_pkg::COORD_W-1:0] col,
                             input logic [raf_pkg::ALPHA_W-1:0] alpha, input logic last);
      start              <= 1'b1;
      req_pixel_row      <= row;
      req_pixel_col      <= col;
      req_pixel_alpha    <= alpha;
      req_last_in_region <= last;
      do @(posedge clock); while (busy !== 1'b0);
   endtask

   task automatic rest(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (book.pending() != 0)
         @(posedge clock);
   endtask

   task automatic set_falloff(input logic [raf_pkg::COORD_W-1:0] col,
                              input logic [raf_pkg::COORD_W-1:0] row,
                              input logic [raf_pkg::ALPHA_W-1:0] max_alpha,
                              input logic [raf_pkg::SCALE_W-1:0] scale);
      logic [raf_pkg::CSR_IDX_W-1:0] order [4];
      logic [raf_pkg::SCALE_W-1:0]   data [4];
      order = '{raf_pkg::CSR_CENTER_COL, raf_pkg::CSR_CENTER_ROW,
                raf_pkg::CSR_MAX_ALPHA, raf_pkg::CSR_FALLOFF_SCALE};
      data  = '{raf_pkg::SCALE_W'(col), raf_pkg::SCALE_W'(row),
                raf_pkg::SCALE_W'(max_alpha), scale};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= data[i];
         do @(posedge clock); while (csr_ready !== 1'b1);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_pixels(input int count, input bit idle);
      logic [raf_pkg::COORD_W-1:0] row, col;
      logic [raf_pkg::ALPHA_W-1:0] alpha;
      int                          span;
      int                          pick;
      for (int n = 0; n < count; n++) begin
         // Most pixels land near the centre, where the falloff leaves something.
         span = ($urandom_range(0, 3) == 0) ? 2047 : 255;
         if ($urandom_range(0, 3) == 0) begin
            row = raf_pkg::COORD_W'($urandom);
            col = raf_pkg::COORD_W'($urandom);
         end else begin
            row = book.center_row + raf_pkg::COORD_W'($urandom_range(0, 2 * span) - span);
            col = book.center_col + raf_pkg::COORD_W'($urandom_range(0, 2 * span) - span);
         end
         pick = $urandom_range(0, 7);
         if (pick == 0)
            alpha = '0;
         else if (pick == 1)
            alpha = '1;
         else
            alpha = raf_pkg::ALPHA_W'($urandom_range(1, 255));
         send_pixel(row, col, alpha, $urandom_range(0, 7) == 0);
         if (idle && $urandom_range(0, 3) == 0)
            rest($urandom_range(1, 16));
      end
   endtask

   task automatic run_phase(input logic [raf_pkg::COORD_W-1:0] col,
                            input logic [raf_pkg::COORD_W-1:0] row,
                            input logic [raf_pkg::ALPHA_W-1:0] max_alpha,
                            input logic [raf_pkg::SCALE_W-1:0] scale, input bit idle);
      set_falloff(col, row, max_alpha, scale);
      // The centre itself and the point opposite it on the grid.
      send_pixel(row, col, '1, 1'b1);
      send_pixel(~row, ~col, '1, 1'b0);
      random_pixels(150, idle);
   endtask

   initial begin
      logic [raf_pkg::SCALE_W-1:0] scale;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: centre at the origin, full alpha, drop of one per pixel of distance.
      send_pixel(12'd0, 12'd0, 8'd0, 1'b0);
      send_pixel(12'd0, 12'd0, 8'd255, 1'b1);
      send_pixel(12'd0, 12'd0, 8'd1, 1'b0);
      send_pixel(12'd4095, 12'd4095, 8'd255, 1'b1);
      send_pixel(12'd4095, 12'd4095, 8'd0, 1'b0);
      send_pixel(12'd3, 12'd4, 8'd200, 1'b0);
      rest(3);
      send_pixel(12'd0, 12'd100, 8'd255, 1'b0);
      send_pixel(12'd100, 12'd0, 8'd128, 1'b1);
      send_pixel(12'd0, 12'd254, 8'd255, 1'b0);
      send_pixel(12'd0, 12'd253, 8'd255, 1'b0);
      rest(1);
      send_pixel(12'd4095, 12'd0, 8'd255, 1'b0);
      send_pixel(12'd0, 12'd4095, 8'd255, 1'b1);
      send_pixel(12'd2, 12'd2, 8'd255, 1'b0);
      send_pixel(12'd2730, 12'd1365, 8'd170, 1'b0);
      send_pixel(12'd1365, 12'd2730, 8'd85, 1'b1);

      run_phase(12'd0, 12'd0, 8'd255, 17'd256, 1'b1);
      run_phase(12'd4095, 12'd4095, 8'd0, 17'd0, 1'b1);
      run_phase(12'd4095, 12'd0, 8'd255, 17'h1FFFF, 1'b1);
      run_phase(12'd0, 12'd4095, 8'd1, 17'd65536, 1'b1);
      run_phase(12'd2048, 12'd2048, 8'd255, 17'd1, 1'b1);
      for (int p = 0; p < 4; p++) begin
         if ($urandom_range(0, 3) == 0)
            scale = raf_pkg::SCALE_W'($urandom_range(0, 131071));
         else
            scale = raf_pkg::SCALE_W'(65536 / $urandom_range(1, 1024));
         run_phase(raf_pkg::COORD_W'($urandom), raf_pkg::COORD_W'($urandom),
                   ($urandom_range(0, 1) == 0) ? 8'd255
                                               : raf_pkg::ALPHA_W'($urandom_range(1, 255)),
                   scale, p != 3);
      end

      drain();
      repeat (raf_pkg::LATENCY + 4) @(posedge clock);
      if (book.pending() != 0) begin
         $display("%0t: %0d result words never arrived", $time, book.pending());
         book.errors++;
      end
      if (book.errors == 0)
         $display("radial_alpha_falloff_top test passed");
      else
         $display("radial_alpha_falloff_top test failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("radial_alpha_falloff_top test failed");
      $finish;
   end

endmodule
`default_nettype wire
